/* src/assert_macros.svh */
// Assertion macros shared by the RTL of the phase current offset calibrator.
// Every macro expects clk_i and the active-low reset rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define PCOC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Precondition in one cycle implies the consequence in the next.
`define PCOC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* src/pcoc_pkg.sv */
// Shared types and constants of the phase current offset calibrator.
// No dependencies; imported by every module of the block.
package pcoc_pkg;

  localparam int ADC_W       = 12;
  localparam int GAIN_W      = 24;
  localparam int CUR_W       = 20;
  localparam int CURV_W      = 21;
  localparam int CNT_W       = 7;
  localparam int FRAC_BITS   = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam int CUR_MAX_MAG = (1 << (CUR_W - 1)) - 1;
  localparam int CUR_MIN_MAG = 1 << (CUR_W - 1);
  localparam logic signed [CUR_W-1:0] CUR_MAX_VAL = {1'b0, {(CUR_W - 1){1'b1}}};
  localparam logic signed [CUR_W-1:0] CUR_MIN_VAL = {1'b1, {(CUR_W - 1){1'b0}}};

  localparam logic signed [GAIN_W-1:0] GAIN_RESET = -24'sd528150;

  // register index taken from the word address
  localparam logic REG_GAIN = 1'b0;

  typedef enum logic {
    OP_CAL     = 1'b0,
    OP_CONVERT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STEP_START  = 2'd0,
    STEP_ACCUM  = 2'd1,
    STEP_FINISH = 2'd2,
    STEP_DONE   = 2'd3
  } step_e;

  typedef struct packed {
    op_e              op;
    logic [ADC_W-1:0] u;
    logic [ADC_W-1:0] w;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* src/pcoc_front.sv */
// Front end: input register that takes items, masks the samples and classifies them.
// Depends on pcoc_pkg; feeds pcoc_fifo.
module pcoc_front import pcoc_pkg::*; #(
  parameter int ADC_BITS = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             action_i,
  input  logic [ADC_W-1:0] adc_u_i,
  input  logic [ADC_W-1:0] adc_w_i,
  input  q_stat_t          q_stat_i,
  output logic             push_o,
  output item_t            push_item_o
);

  localparam int SMP_W = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
  localparam logic [ADC_W-1:0] SMP_MASK = {ADC_W{1'b1}} >> (ADC_W - SMP_W);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  assign push_o      = valid_q && !q_stat_i.full;
  assign in_stall_o  = valid_q && q_stat_i.full;
  assign accept      = in_valid_i && !in_stall_o;
  assign push_item_o = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.op <= action_i ? OP_CONVERT : OP_CAL;
      item_q.u  <= adc_u_i & SMP_MASK;
      item_q.w  <= adc_w_i & SMP_MASK;
    end
  end

endmodule

/* src/pcoc_fifo.sv */
// Short queue between the front end and the execute back end.
// Depends on pcoc_pkg for the item type and status struct.
module pcoc_fifo import pcoc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  item_t   item_i,
  input  logic    pop_i,
  output item_t   item_o,
  output q_stat_t stat_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_Q_W = $clog2(DEPTH + 1);

  item_t              mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_Q_W-1:0] count_q, count_d;

  assign item_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CNT_Q_W'(DEPTH));
  assign stat_o.empty = (count_q == '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* src/pcoc_back.sv */
// Back end: calibration sequencer, offset store, gain multiply, rounding and output register.
// Depends on pcoc_pkg and assert_macros.svh; takes items from pcoc_fifo.
`include "assert_macros.svh"
module pcoc_back import pcoc_pkg::*; #(
  parameter int CAL_SAMPLES = 100,
  parameter int ADC_BITS    = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  q_stat_t                  q_stat_i,
  input  item_t                    item_i,
  output logic                     pop_o,
  input  logic signed [GAIN_W-1:0] gain_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [CUR_W-1:0]  cur_u_o,
  output logic signed [CURV_W-1:0] cur_v_o,
  output logic signed [CUR_W-1:0]  cur_w_o,
  output logic                     ready_res_o,
  output logic                     power_on_o
);

  localparam int SMP_W = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
  localparam longint SUM_MAX = longint'(CAL_SAMPLES) * ((longint'(1) << SMP_W) - 1);
  localparam int SUM_W   = $clog2(SUM_MAX + 1);
  localparam int DIFF_W  = SUM_W + 1;
  localparam int PROD_W  = DIFF_W + GAIN_W;
  localparam int QX_W    = ((PROD_W - FRAC_BITS) > CUR_W ? PROD_W - FRAC_BITS : CUR_W) + 1;
  // exact truncating divide by CAL_SAMPLES via rounded-up reciprocal
  localparam int DIV_SH  = SUM_W + $clog2(CAL_SAMPLES);
  localparam int RECIP_W = SUM_W + 2;
  localparam int QPROD_W = DIV_SH + SUM_W;
  localparam longint RECIP =
    ((longint'(1) << DIV_SH) + longint'(CAL_SAMPLES) - 1) / longint'(CAL_SAMPLES);
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

  function automatic logic signed [CUR_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic              neg;
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] rnd;
    logic [QX_W-1:0]   qx;
    logic signed [CUR_W-1:0] res;
    neg = p[PROD_W-1];
    mag = neg ? (~p + 1'b1) : p;
    rnd = mag + ROUND_HALF;   // ties go away from zero
    qx  = QX_W'(rnd >> FRAC_BITS);
    if (neg) begin
      res = (qx > QX_W'(CUR_MIN_MAG)) ? CUR_MIN_VAL : -$signed(qx[CUR_W-1:0]);
    end else begin
      res = (qx > QX_W'(CUR_MAX_MAG)) ? CUR_MAX_VAL : $signed(qx[CUR_W-1:0]);
    end
    return res;
  endfunction

  step_e             step_q, step_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SUM_W-1:0]  off_u_q, off_u_d, off_w_q, off_w_d;
  logic              ready_q, ready_d, power_q, power_d;
  logic              div_phase_q, div_phase_d;
  logic [QPROD_W-1:0] dq_u_q, dq_w_q;
  logic              dq_load;

  logic [SMP_W-1:0]  smp_u, smp_w;
  logic signed [DIFF_W-1:0] diff_u, diff_w;
  logic signed [PROD_W-1:0] prod_u, prod_w;
  logic              has_item, is_div, out_free, p_free, p_load;

  logic              p_valid_q, p_valid_d;
  logic signed [PROD_W-1:0] p_prod_u_q, p_prod_w_q;
  logic              p_ready_q, p_power_q;

  logic              out_valid_q, out_valid_d, out_load;
  logic signed [CUR_W-1:0] cu, cw;

  assign smp_u  = item_i.u[SMP_W-1:0];
  assign smp_w  = item_i.w[SMP_W-1:0];
  assign diff_u = $signed({1'b0, SUM_W'(smp_u)}) - $signed({1'b0, off_u_q});
  assign diff_w = $signed({1'b0, SUM_W'(smp_w)}) - $signed({1'b0, off_w_q});
  assign prod_u = PROD_W'(diff_u) * PROD_W'(gain_i);
  assign prod_w = PROD_W'(diff_w) * PROD_W'(gain_i);

  assign has_item = !q_stat_i.empty;
  assign is_div   = (item_i.op == OP_CAL) && (step_q == STEP_ACCUM) &&
                    (count_q == CNT_W'(CAL_SAMPLES));
  assign out_free = !out_valid_q || !out_stall_i;
  assign p_free   = !p_valid_q || out_free;

  // execute stage: sequencer next state and queue pop
  always_comb begin
    step_d      = step_q;
    count_d     = count_q;
    off_u_d     = off_u_q;
    off_w_d     = off_w_q;
    ready_d     = ready_q;
    power_d     = power_q;
    div_phase_d = div_phase_q;
    dq_load     = 1'b0;
    pop_o       = 1'b0;
    p_load      = 1'b0;
    if (has_item) begin
      if (is_div && !div_phase_q) begin
        // first step of the divide: register the reciprocal products
        dq_load     = 1'b1;
        div_phase_d = 1'b1;
      end else if (p_free) begin
        pop_o  = 1'b1;
        p_load = 1'b1;
        unique case (item_i.op)
          OP_CAL: begin
            unique case (step_q)
              STEP_START: begin
                power_d = 1'b1;
                step_d  = STEP_ACCUM;
              end
              STEP_ACCUM: begin
                if (count_q < CNT_W'(CAL_SAMPLES)) begin
                  off_u_d = off_u_q + SUM_W'(smp_u);
                  off_w_d = off_w_q + SUM_W'(smp_w);
                  count_d = count_q + 1'b1;
                end else begin
                  off_u_d     = dq_u_q[DIV_SH +: SUM_W];
                  off_w_d     = dq_w_q[DIV_SH +: SUM_W];
                  step_d      = STEP_FINISH;
                  div_phase_d = 1'b0;
                end
              end
              STEP_FINISH: begin
                power_d = 1'b0;
                ready_d = 1'b1;
                step_d  = STEP_DONE;
              end
              default: begin
                // calibrated: further ticks change nothing
              end
            endcase
          end
          OP_CONVERT: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_START;
      count_q     <= '0;
      off_u_q     <= '0;
      off_w_q     <= '0;
      ready_q     <= 1'b0;
      power_q     <= 1'b0;
      div_phase_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      count_q     <= count_d;
      off_u_q     <= off_u_d;
      off_w_q     <= off_w_d;
      ready_q     <= ready_d;
      power_q     <= power_d;
      div_phase_q <= div_phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dq_load) begin
      dq_u_q <= QPROD_W'(off_u_q) * QPROD_W'(RECIP_C);
      dq_w_q <= QPROD_W'(off_w_q) * QPROD_W'(RECIP_C);
    end
  end

  // product stage; calibration ticks carry a zero product
  assign p_valid_d = p_load || (p_valid_q && !out_free);

  always_ff @(posedge clk_i) begin
    if (p_load) begin
      p_prod_u_q <= (item_i.op == OP_CONVERT) ? prod_u : '0;
      p_prod_w_q <= (item_i.op == OP_CONVERT) ? prod_w : '0;
      p_ready_q  <= ready_d;
      p_power_q  <= power_d;
    end
  end

  // rounding, saturation and output register
  assign cu          = round_sat(p_prod_u_q);
  assign cw          = round_sat(p_prod_w_q);
  assign out_load    = p_valid_q && out_free;
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      p_valid_q   <= p_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cur_u_o     <= cu;
      cur_w_o     <= cw;
      cur_v_o     <= -CURV_W'(cu) - CURV_W'(cw);
      ready_res_o <= p_ready_q;
      power_on_o  <= p_power_q;
    end
  end

  `PCOC_ASSERT_NEXT(a_ready_sticky, ready_q, ready_q, "ready flag dropped after calibration")
  `PCOC_ASSERT(a_flags_excl, !(ready_q && power_q), "power stage on while calibrated")
  `PCOC_ASSERT(a_div_state, !div_phase_q || is_div, "divide pending outside end of accumulation")
  `PCOC_ASSERT(a_count_bound, count_q <= CNT_W'(CAL_SAMPLES), "sample count overran")

endmodule

/* src/phase_current_offset_calibrator.sv */
// Phase current offset calibrator, top level: APB gain register, front end, queue, back end.
// Results pass the input register, the queue, the product register and the output register.
// Throughput: one item per cycle unless the output stalls; the tick that divides the offset
// sums holds execute (reciprocal multiply, then offset write); later items queue behind it.
// Reset is asynchronous, active low; it clears the sequencer, flags, offsets and the queue
// and loads the reset gain. No clearing pass is needed.
module phase_current_offset_calibrator import pcoc_pkg::*; #(
  parameter int CAL_SAMPLES = 100,
  parameter int ADC_BITS    = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     action_i,
  input  logic [ADC_W-1:0]         adc_u_i,
  input  logic [ADC_W-1:0]         adc_w_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [CUR_W-1:0]  cur_u_o,
  output logic signed [CURV_W-1:0] cur_v_o,
  output logic signed [CUR_W-1:0]  cur_w_o,
  output logic                     ready_res_o,
  output logic                     power_on_o
);

  logic signed [GAIN_W-1:0] gain_q;
  logic    reg_idx;
  logic    gain_wr;
  logic    push, pop;
  item_t   push_item, head_item;
  q_stat_t q_stat;

  // word address: bit 2 selects the register, byte offset ignored
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;
  assign gain_wr = psel && penable && pwrite && pready && (reg_idx == REG_GAIN);
  assign prdata  = (reg_idx == REG_GAIN) ? PDATA_W'(gain_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (gain_wr) begin
      gain_q <= $signed(pwdata[GAIN_W-1:0]);
    end
  end

  pcoc_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .adc_u_i     (adc_u_i),
    .adc_w_i     (adc_w_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_item_o (push_item)
  );

  pcoc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (q_stat)
  );

  pcoc_back #(
    .CAL_SAMPLES (CAL_SAMPLES),
    .ADC_BITS    (ADC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .item_i      (head_item),
    .pop_o       (pop),
    .gain_i      (gain_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cur_u_o     (cur_u_o),
    .cur_v_o     (cur_v_o),
    .cur_w_o     (cur_w_o),
    .ready_res_o (ready_res_o),
    .power_on_o  (power_on_o)
  );

endmodule

/* bench/phase_current_offset_calibrator_test.sv */
// Self-checking bench for phase_current_offset_calibrator: offset calibration and currents.
// Depends on pcoc_pkg and the calibrator RTL; gain written and read over the APB port.
`timescale 1ns / 100ps

module phase_current_offset_calibrator_test;
  import pcoc_pkg::*;

  localparam int CAL_TICKS     = 100;
  localparam int PHASE_ITEMS   = 150;
  localparam int TICK_PCT      = 35;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int DIRECTED_ROWS = 12;
  localparam int GAIN_PHASES   = 8;

  typedef struct packed {
    logic signed [CUR_W-1:0]  cur_u;
    logic signed [CURV_W-1:0] cur_v;
    logic signed [CUR_W-1:0]  cur_w;
    logic                     ready;
    logic                     power;
  } currents_t;

  typedef struct packed {
    op_e              op;
    logic [ADC_W-1:0] u;
    logic [ADC_W-1:0] w;
    logic             typed;
    currents_t        res;
  } stim_row_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_e;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [PADDR_W-1:0]       paddr;
  logic [PDATA_W-1:0]       pwdata;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     action_i;
  logic [ADC_W-1:0]         adc_u_i;
  logic [ADC_W-1:0]         adc_w_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [CUR_W-1:0]  cur_u_o;
  logic signed [CURV_W-1:0] cur_v_o;
  logic signed [CUR_W-1:0]  cur_w_o;
  logic                     ready_res_o;
  logic                     power_on_o;

  // predictor state
  step_e                    cal_step     = STEP_START;
  logic [CNT_W-1:0]         cal_count    = '0;
  int unsigned              sum_u        = 0;
  int unsigned              sum_w        = 0;
  logic                     cal_ready    = 1'b0;
  logic                     cal_power    = 1'b0;
  logic signed [GAIN_W-1:0] gain_setting = GAIN_RESET;

  currents_t expected_currents[$];
  int        mismatches    = 0;
  int        items_sent    = 0;
  int        results_seen  = 0;
  int        cal_ticks     = 0;
  int        saturations   = 0;
  int        cycle_count   = 0;

  phase_current_offset_calibrator #(
    .CAL_SAMPLES(CAL_TICKS),
    .ADC_BITS   (ADC_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .adc_u_i    (adc_u_i),
    .adc_w_i    (adc_w_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cur_u_o    (cur_u_o),
    .cur_v_o    (cur_v_o),
    .cur_w_o    (cur_w_o),
    .ready_res_o(ready_res_o),
    .power_on_o (power_on_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string field, longint got, longint want);
    mismatches++;
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", field, got, want,
             results_seen);
  endtask

  // sample minus offset, scaled by the Q16 gain, rounded half away from zero, saturated
  function automatic logic signed [CUR_W-1:0] scale_phase(int unsigned sample,
                                                          int unsigned offset);
    longint diff;
    longint prod;
    longint mag;
    longint q;
    diff = longint'(sample) - longint'(offset);
    prod = diff * longint'(gain_setting);
    mag  = (prod < 0) ? -prod : prod;
    q    = (mag + 32768) >>> FRAC_BITS;
    if (prod < 0) q = -q;
    if (q > CUR_MAX_MAG) q = CUR_MAX_MAG;
    if (q < -CUR_MIN_MAG) q = -CUR_MIN_MAG;
    return q[CUR_W-1:0];
  endfunction

  function automatic currents_t predict_currents(op_e op, logic [ADC_W-1:0] u,
                                                 logic [ADC_W-1:0] w);
    currents_t r;
    r = '0;
    if (op == OP_CAL) begin
      case (cal_step)
        STEP_START: begin
          cal_power = 1'b1;
          cal_step  = STEP_ACCUM;
        end
        STEP_ACCUM: begin
          if (cal_count < CAL_TICKS) begin
            sum_u     = sum_u + u;
            sum_w     = sum_w + w;
            cal_count = cal_count + 1'b1;
          end else begin
            sum_u    = sum_u / CAL_TICKS;
            sum_w    = sum_w / CAL_TICKS;
            cal_step = STEP_FINISH;
          end
        end
        STEP_FINISH: begin
          cal_power = 1'b0;
          cal_ready = 1'b1;
          cal_step  = STEP_DONE;
        end
        default: ;
      endcase
    end else begin
      r.cur_u = scale_phase(u, sum_u);
      r.cur_w = scale_phase(w, sum_w);
      r.cur_v = CURV_W'(-longint'(r.cur_u) - longint'(r.cur_w));
    end
    r.ready = cal_ready;
    r.power = cal_power;
    return r;
  endfunction

  // presents one transaction (called at a falling edge) and returns at the falling edge after it is taken
  task automatic drive_item(op_e op, logic [ADC_W-1:0] u, logic [ADC_W-1:0] w,
                            logic typed, currents_t typed_res);
    currents_t predicted;
    in_valid_i <= 1'b1;
    action_i   <= op;
    adc_u_i    <= u;
    adc_w_i    <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = predict_currents(op, u, w);
    expected_currents.push_back(typed ? typed_res : predicted);
    items_sent++;
    if (op == OP_CAL) cal_ticks++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_currents.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_gain(logic signed [GAIN_W-1:0] gain);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_GAIN, 2'b00};
    pwdata  <= PDATA_W'(gain);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    gain_setting = gain;
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[GAIN_W-1:0] !== gain) begin
      report_mismatch("gain readback", longint'(signed'(prdata[GAIN_W-1:0])), gain);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // receiver: stall behaviour switches at random intervals between none, random, periodic and heavy
  initial begin
    stall_mode_e mode;
    int          mode_left;
    int          phase_cnt;
    out_stall_i = 1'b0;
    mode        = STALL_NONE;
    mode_left   = 0;
    phase_cnt   = 0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode      = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      phase_cnt++;
      case (mode)
        STALL_NONE:     out_stall_i <= 1'b0;
        STALL_RANDOM:   out_stall_i <= ($urandom_range(0, 99) < 30);
        STALL_PERIODIC: out_stall_i <= ((phase_cnt % 5) < 2);
        default:        out_stall_i <= ($urandom_range(0, 99) < 75);
      endcase
    end
  end

  always @(posedge clk_i) begin
    currents_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_currents.size() == 0) begin
        mismatches++;
        $display("UNEXPECTED result %0d: no transaction outstanding", results_seen);
      end else begin
        want = expected_currents.pop_front();
        if (cur_u_o !== want.cur_u) report_mismatch("cur_u", cur_u_o, want.cur_u);
        if (cur_v_o !== want.cur_v) report_mismatch("cur_v", cur_v_o, want.cur_v);
        if (cur_w_o !== want.cur_w) report_mismatch("cur_w", cur_w_o, want.cur_w);
        if (ready_res_o !== want.ready) report_mismatch("ready_res", ready_res_o, want.ready);
        if (power_on_o !== want.power) report_mismatch("power_on", power_on_o, want.power);
        if (cur_u_o == CUR_MAX_VAL || cur_u_o == CUR_MIN_VAL) saturations++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_currents.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    stim_row_t                directed_rows [DIRECTED_ROWS];
    logic signed [GAIN_W-1:0] phase_gains [GAIN_PHASES];
    currents_t                no_res;
    int                       burst_left;
    op_e                      op;
    logic [ADC_W-1:0]         u;
    logic [ADC_W-1:0]         w;

    no_res = '0;
    // reset state with the reset gain: power comes up on the first tick, ready stays low
    directed_rows[0]  = '{OP_CONVERT, 12'd0,    12'd0,    1'b1, '0};
    directed_rows[1]  = '{OP_CONVERT, 12'hFFF,  12'hFFF,  1'b0, '0};
    directed_rows[2]  = '{OP_CONVERT, 12'hFFF,  12'd0,    1'b0, '0};
    directed_rows[3]  = '{OP_CONVERT, 12'd0,    12'hFFF,  1'b0, '0};
    directed_rows[4]  = '{OP_CAL,     12'd0,    12'd0,    1'b1,
                          '{20'sd0, 21'sd0, 20'sd0, 1'b0, 1'b1}};
    directed_rows[5]  = '{OP_CAL,     12'hFFF,  12'hFFF,  1'b1,
                          '{20'sd0, 21'sd0, 20'sd0, 1'b0, 1'b1}};
    directed_rows[6]  = '{OP_CONVERT, 12'd0,    12'd0,    1'b0, '0};
    directed_rows[7]  = '{OP_CAL,     12'hAAA,  12'h555,  1'b1,
                          '{20'sd0, 21'sd0, 20'sd0, 1'b0, 1'b1}};
    directed_rows[8]  = '{OP_CAL,     12'h555,  12'hAAA,  1'b1,
                          '{20'sd0, 21'sd0, 20'sd0, 1'b0, 1'b1}};
    directed_rows[9]  = '{OP_CONVERT, 12'hFFF,  12'hFFF,  1'b0, '0};
    directed_rows[10] = '{OP_CONVERT, 12'h800,  12'h7FF,  1'b0, '0};
    directed_rows[11] = '{OP_CONVERT, 12'h001,  12'hFFE,  1'b0, '0};

    phase_gains[0] = 24'sh7FFFFF;
    phase_gains[1] = -24'sh800000;
    phase_gains[2] = 24'sd0;
    phase_gains[3] = 24'sd1;
    phase_gains[4] = -24'sd1;
    phase_gains[5] = 24'sd65536;
    phase_gains[6] = GAIN_W'($urandom_range(0, 24'hFFFFFF));
    phase_gains[7] = GAIN_RESET;

    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    action_i    = OP_CAL;
    adc_u_i     = '0;
    adc_w_i     = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset value of the gain register
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    paddr   <= {REG_GAIN, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[GAIN_W-1:0] !== GAIN_RESET) begin
      report_mismatch("gain after reset", longint'(signed'(prdata[GAIN_W-1:0])), GAIN_RESET);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      drive_item(directed_rows[i].op, directed_rows[i].u, directed_rows[i].w,
                 directed_rows[i].typed, directed_rows[i].typed ? directed_rows[i].res : no_res);
    end

    // random phases: ticks drive the calibration forward while converts are taken at each gain
    foreach (phase_gains[p]) begin
      wait_idle();
      write_gain(phase_gains[p]);
      @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(0, 99) < TICK_PCT) ? OP_CAL : OP_CONVERT;
        case ($urandom_range(0, 3))
          0, 1: begin
            // realistic samples around mid-scale
            u = ADC_W'(2048 + $urandom_range(0, 160) - 80);
            w = ADC_W'(2048 + $urandom_range(0, 160) - 80);
          end
          2: begin
            u = ADC_W'($urandom_range(0, 1) * 12'hFFF);
            w = ADC_W'($urandom_range(0, 1) * 12'hFFF);
          end
          default: begin
            u = ADC_W'($urandom_range(0, 4095));
            w = ADC_W'($urandom_range(0, 4095));
          end
        endcase
        drive_item(op, u, w, 1'b0, no_res);
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 3) != 0) begin
            in_valid_i <= 1'b0;
            adc_u_i    <= ADC_W'($urandom_range(0, 4095));
            repeat ($urandom_range(1, 8)) @(negedge clk_i);
          end
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d transactions (%0d calibration ticks) over %0d gain settings.",
             items_sent, cal_ticks, GAIN_PHASES + 1);
    $display("Checked %0d results, %0d saturated; calibration ready at end: %0d.",
             results_seen, saturations, cal_ready);
    if (mismatches == 0 && expected_currents.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
